[rtl/tdf_pkg.sv]
// Shared types and constants for the TLV datagram deframer.
// Used by every module under rtl; depends on nothing else.
`default_nettype none
package tdf_pkg;

	localparam int unsigned CFG_INDEX_W     = 1;
	localparam int unsigned CFG_DATA_W      = 8;
	localparam logic [CFG_INDEX_W-1:0] CFG_MAGIC   = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_VERSION = 1'd1;
	localparam logic [7:0] MAGIC_RESET      = 8'd93;
	localparam logic [7:0] VERSION_RESET    = 8'd2;

	localparam int unsigned QUEUE_DEPTH_DEF = 4;
	localparam int unsigned OUT_DATA_W      = 40;

	typedef enum logic [1:0] {
		KIND_VALUE  = 2'd0,
		KIND_EMPTY  = 2'd1,
		KIND_STATUS = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_BAD_HDR = 2'd1,
		ST_TRUNC   = 2'd2
	} status_t;

	typedef enum logic [6:0] {
		PH_MAGIC   = 7'b0000001,
		PH_VERSION = 7'b0000010,
		PH_LEN_HI  = 7'b0000100,
		PH_LEN_LO  = 7'b0001000,
		PH_TYPE    = 7'b0010000,
		PH_LENGTH  = 7'b0100000,
		PH_VALUE   = 7'b1000000
	} phase_t;

	// Work for the back end caused by one input beat: an optional TLV result
	// followed by an optional frame status result.
	typedef struct packed {
		logic       has_tlv;
		kind_t      tlv_kind;
		logic [7:0] tlv_type;
		logic [7:0] tlv_length;
		logic [7:0] value_byte;
		logic [7:0] value_index;
		logic       tlv_done;
		logic       has_status;
		status_t    status;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_stat_t;

endpackage
`default_nettype wire

[rtl/tdf_front.sv]
// Front end of the deframer: header check, TLV parsing and configuration registers.
// Depends on tdf_pkg; emits one job per input beat that causes any result.
`default_nettype none
module tdf_front
	import tdf_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_we,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data,
	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire logic [7:0]             in_byte,
	input  wire logic                   in_last,
	input  wire logic                   queue_full,
	output logic                        push,
	output job_t                        job
);

	logic [7:0]  magic_q, version_q;
	phase_t      phase_q, phase_d;
	logic        hb_q, hb_d;
	logic [15:0] blen_q, blen_d;
	logic [15:0] used_q, used_d;
	logic [7:0]  ctype_q, ctype_d;
	logic [7:0]  clen_q, clen_d;
	logic [7:0]  vpos_q, vpos_d;
	logic        accept, body_active, val_done, hdr_phase;

	assign in_ready = !queue_full;
	assign accept   = in_valid && in_ready;
	assign body_active = !hb_q && (used_q < blen_q);
	assign val_done = ({1'b0, vpos_q} + 9'd1) >= {1'b0, clen_q};

	always_comb begin
		phase_d = phase_q;
		hb_d    = hb_q;
		blen_d  = blen_q;
		used_d  = used_q;
		ctype_d = ctype_q;
		clen_d  = clen_q;
		vpos_d  = vpos_q;
		job     = '0;
		case (phase_q)
			PH_MAGIC: begin
				hb_d    = hb_q | (in_byte != magic_q);
				phase_d = PH_VERSION;
			end
			PH_VERSION: begin
				hb_d    = hb_q | (in_byte != version_q);
				phase_d = PH_LEN_HI;
			end
			PH_LEN_HI: begin
				blen_d  = {in_byte, 8'h00};
				phase_d = PH_LEN_LO;
			end
			PH_LEN_LO: begin
				blen_d  = {blen_q[15:8], in_byte};
				used_d  = '0;
				phase_d = PH_TYPE;
			end
			PH_TYPE: begin
				if (body_active) begin
					used_d  = used_q + 16'd1;
					ctype_d = in_byte;
					phase_d = PH_LENGTH;
				end
			end
			PH_LENGTH: begin
				if (body_active) begin
					used_d = used_q + 16'd1;
					clen_d = in_byte;
					vpos_d = '0;
					if (in_byte == 8'd0) begin
						job.has_tlv  = 1'b1;
						job.tlv_kind = KIND_EMPTY;
						job.tlv_type = ctype_q;
						job.tlv_done = 1'b1;
						phase_d      = PH_TYPE;
					end else begin
						phase_d = PH_VALUE;
					end
				end
			end
			PH_VALUE: begin
				if (body_active) begin
					used_d          = used_q + 16'd1;
					job.has_tlv     = 1'b1;
					job.tlv_kind    = KIND_VALUE;
					job.tlv_type    = ctype_q;
					job.tlv_length  = clen_q;
					job.value_byte  = in_byte;
					job.value_index = vpos_q;
					job.tlv_done    = val_done;
					if (val_done) begin
						phase_d = PH_TYPE;
						vpos_d  = '0;
					end else begin
						vpos_d = vpos_q + 8'd1;
					end
				end
			end
			default: begin
			end
		endcase

		hdr_phase = (phase_d == PH_MAGIC) || (phase_d == PH_VERSION) ||
			(phase_d == PH_LEN_HI) || (phase_d == PH_LEN_LO);
		job.has_status = in_last;
		if (hb_d) begin
			job.status = ST_BAD_HDR;
		end else if (hdr_phase || (used_d < blen_d) || (phase_d != PH_TYPE)) begin
			job.status = ST_TRUNC;
		end else begin
			job.status = ST_OK;
		end
	end

	assign push = accept && (job.has_tlv || job.has_status);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magic_q   <= MAGIC_RESET;
			version_q <= VERSION_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MAGIC:   magic_q   <= cfg_data[7:0];
				CFG_VERSION: version_q <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_MAGIC;
			hb_q    <= 1'b0;
			blen_q  <= '0;
			used_q  <= '0;
			ctype_q <= '0;
			clen_q  <= '0;
			vpos_q  <= '0;
		end else if (accept) begin
			if (in_last) begin
				phase_q <= PH_MAGIC;
				hb_q    <= 1'b0;
				blen_q  <= '0;
				used_q  <= '0;
				ctype_q <= '0;
				clen_q  <= '0;
				vpos_q  <= '0;
			end else begin
				phase_q <= phase_d;
				hb_q    <= hb_d;
				blen_q  <= blen_d;
				used_q  <= used_d;
				ctype_q <= ctype_d;
				clen_q  <= clen_d;
				vpos_q  <= vpos_d;
			end
		end
	end

endmodule
`default_nettype wire

[rtl/tdf_queue.sv]
// Short job queue between the deframer's front and back ends.
// Depends on tdf_pkg for the job and status types.
`default_nettype none
module tdf_queue
	import tdf_pkg::*;
#(
	parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  wire job_t  push_job,
	input  wire logic  pop,
	output job_t       head,
	output queue_stat_t stat
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	job_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	assign stat.full  = (count_q == FULL_CNT);
	assign stat.empty = (count_q == '0);
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

[rtl/tdf_back.sv]
// Back end of the deframer: expands queued jobs into result beats.
// Depends on tdf_pkg; drives the registered output stream.
`default_nettype none
module tdf_back
	import tdf_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire job_t                   head,
	input  wire queue_stat_t            qstat,
	output logic                        pop,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output logic [OUT_DATA_W-1:0]       out_data,
	output kind_t                       out_kind,
	output logic                        out_last
);

	logic  valid_q, second_q, load, split;
	kind_t kind_q;
	logic  last_q;
	logic [OUT_DATA_W-1:0] data_q;
	logic [OUT_DATA_W-1:0] tlv_word, status_word;

	assign load  = (!valid_q || out_ready) && !qstat.empty;
	assign split = head.has_tlv && head.has_status && !second_q;
	assign pop   = load && !split;

	assign tlv_word = {5'd0, ST_OK, head.tlv_done, head.value_index,
		head.value_byte, head.tlv_length, head.tlv_type};
	assign status_word = {5'd0, head.status, 1'b0, 32'd0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= 1'b0;
			second_q <= 1'b0;
		end else begin
			if (load) begin
				valid_q  <= 1'b1;
				second_q <= split;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (head.has_tlv && !second_q) begin
				data_q <= tlv_word;
				kind_q <= head.tlv_kind;
				last_q <= !head.has_status;
			end else begin
				data_q <= status_word;
				kind_q <= KIND_STATUS;
				last_q <= 1'b1;
			end
		end
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;
	assign out_kind  = kind_q;
	assign out_last  = last_q;

endmodule
`default_nettype wire

[rtl/tlv_datagram_deframer_core.sv]
// Top level of the TLV datagram deframer: front end, job queue and back end.
// Depends on tdf_pkg, tdf_front, tdf_queue and tdf_back.
`default_nettype none
// The block takes one datagram byte per beat and checks its four-byte header
// (magic, version, big-endian body length), then splits the body into TLVs.
// Each value byte gives one result beat, each empty TLV one marker beat, and
// the byte marked by tlast also gives a frame status beat; tlast on the output
// marks the final beat caused by one input byte. An input byte is taken every
// cycle while the job queue has room; the output side delivers one beat per
// cycle while m_tready is high, so a byte that causes two results keeps the
// back end busy longer and the queue absorbs the difference.
// Configuration writes are taken at any time but must only change while idle.
module tlv_datagram_deframer_core
	import tdf_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_we,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data,
	input  wire logic                   s_tvalid,
	output logic                        s_tready,
	input  wire logic [7:0]             s_tdata,  // data_byte
	input  wire logic                   s_tlast,  // frame_end
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	// tlv_type, tlv_length, value_byte, value_index, tlv_done, frame_status, zero fill
	output logic [OUT_DATA_W-1:0]       m_tdata,
	output logic [1:0]                  m_tuser,  // kind
	output logic                        m_tlast   // run_last
);

	logic        push, pop;
	job_t        push_job, head;
	queue_stat_t qstat;
	kind_t       out_kind;

	tdf_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_byte    (s_tdata),
		.in_last    (s_tlast),
		.queue_full (qstat.full),
		.push       (push),
		.job        (push_job)
	);

	tdf_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head     (head),
		.stat     (qstat)
	);

	tdf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.qstat     (qstat),
		.pop       (pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata),
		.out_kind  (out_kind),
		.out_last  (m_tlast)
	);

	assign m_tuser = out_kind;

`ifndef SYNTH
	a_status_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == KIND_STATUS) |-> m_tlast)
		else $error("Frame status beat without run end.");

	a_empty_is_done: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == KIND_EMPTY) |-> m_tdata[32] && (m_tdata[31:24] == 8'd0))
		else $error("Empty TLV marker without done mark.");

	a_drain_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		qstat.empty && m_tready |=> !m_tvalid)
		else $error("Output beat appeared with no queued job.");
`endif

endmodule
`default_nettype wire
